// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rapq_pkg.sv =====
// Shared widths, op codes and controller/datapath command and status types.
package rapq_pkg;

  localparam int LEAF_W = 11;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;

  localparam logic [LEAF_W-1:0] LEAF_COUNT_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic load;        // latch a request and start at the root
    logic clear_step;  // zero one tag entry of the sweep
    logic visit_read;  // read the tag of a covered node
    logic go_left;     // descend to the left child
    logic go_right;    // descend to the right child
    logic push_right;  // save the right child for later
    logic pop;         // resume at the saved node
    logic add_write;   // write back tag plus add value
    logic q_read;      // read the tag on the query path
    logic q_acc;       // accumulate the tag just read
    logic out_load;    // move the path sum to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic oob;          // node index beyond the tag store
    logic covered;      // node span lies inside the add range
    logic leaf;         // node spans a single position
    logic want_left;    // add range reaches the left half
    logic want_right;   // add range reaches the right half
    logic query_right;  // query position lies in the right half
    logic range_empty;  // clipped add range holds nothing
    logic stack_empty;
    logic clear_last;   // sweep is at its last entry
    logic out_free;     // output register can take a result
  } dp_status_t;

endpackage

// ===== sv/rapq_ifs.sv =====
// Request, result and configuration channel interfaces.
interface rapq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rapq_pkg::OP_W-1:0]      op;
  logic        [rapq_pkg::LEAF_W-1:0]    range_low;
  logic        [rapq_pkg::LEAF_W-1:0]    range_high;
  logic signed [rapq_pkg::DATA_W-1:0]    add_value;
  logic        [rapq_pkg::LEAF_W-1:0]    position;

  modport source (output valid, op, range_low, range_high, add_value, position,
                  input ready);
  modport sink (input valid, op, range_low, range_high, add_value, position,
                output ready);
endinterface

interface rapq_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rapq_pkg::DATA_W-1:0] point_sum;

  modport source (output valid, point_sum, input ready);
  modport sink (input valid, point_sum, output ready);
endinterface

interface rapq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rapq_pkg::LEAF_W-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/rapq_ctrl.sv =====
// Controller state machine sequencing clear sweeps, range adds and point queries.
module rapq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [rapq_pkg::OP_W-1:0] op,
  output logic                 in_ready,
  input  rapq_pkg::dp_status_t st,
  output rapq_pkg::dp_cmd_t    cmd
);
  import rapq_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_VISIT = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_QREAD = 3'd4;
  localparam logic [2:0] S_QACC  = 3'd5;
  localparam logic [2:0] S_QDONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (op)
            OP_CLEAR: state_next = S_CLEAR;
            OP_ADD:   state_next = S_VISIT;
            OP_QUERY: state_next = S_QREAD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_VISIT: begin
        if (st.range_empty || st.oob || (!st.covered && st.leaf)) begin
          // nothing to do here: resume a saved node or finish
          if (st.stack_empty) begin
            state_next = S_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end else if (st.covered) begin
          cmd.visit_read = 1'b1;
          state_next     = S_ADD;
        end else if (st.want_left) begin
          cmd.go_left    = 1'b1;
          cmd.push_right = st.want_right;
        end else begin
          cmd.go_right = 1'b1;
        end
      end
      S_ADD: begin
        cmd.add_write = 1'b1;
        if (st.stack_empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_VISIT;
        end
      end
      S_QREAD: begin
        if (st.oob) begin
          state_next = S_QDONE;
        end else begin
          cmd.q_read = 1'b1;
          state_next = S_QACC;
        end
      end
      S_QACC: begin
        cmd.q_acc = 1'b1;
        if (st.leaf) begin
          state_next = S_QDONE;
        end else begin
          cmd.go_right = st.query_right;
          cmd.go_left  = !st.query_right;
          state_next   = S_QREAD;
        end
      end
      S_QDONE: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/rapq_dp.sv =====
// Datapath: tag memory, node walker with return stack, path sum and output register.
module rapq_dp #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic        [rapq_pkg::LEAF_W-1:0]   cfg_data,
  input  logic        [rapq_pkg::LEAF_W-1:0]   range_low,
  input  logic        [rapq_pkg::LEAF_W-1:0]   range_high,
  input  logic signed [rapq_pkg::DATA_W-1:0]   add_value,
  input  logic        [rapq_pkg::LEAF_W-1:0]   position,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [rapq_pkg::DATA_W-1:0]   point_sum,
  input  rapq_pkg::dp_cmd_t                    cmd,
  output rapq_pkg::dp_status_t                 st
);
  import rapq_pkg::*;

  localparam int TAG_DEPTH = 4 * MAX_LEAVES;
  localparam int NODE_W    = $clog2(TAG_DEPTH);
  localparam int SPAN_MAX  = (MAX_LEAVES < 2047) ? MAX_LEAVES : 2047;
  localparam int STK_D     = $clog2(SPAN_MAX) + 1;
  localparam int SI_W      = $clog2(STK_D);
  localparam int SP_W      = $clog2(STK_D + 1);

  typedef struct packed {
    logic [NODE_W:0]     node;
    logic [LEAF_W-1:0]   lo;
    logic [LEAF_W-1:0]   hi;
  } stk_ent_t;

  logic [DATA_W-1:0] mem [TAG_DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [LEAF_W-1:0] leaf_count;
  logic [NODE_W:0]   node;
  logic [LEAF_W-1:0] lo;
  logic [LEAF_W-1:0] hi;
  logic [LEAF_W-1:0] ql;
  logic [LEAF_W-1:0] qh;
  logic [LEAF_W-1:0] pos;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] sum;
  logic [NODE_W-1:0] clr_cnt;
  stk_ent_t          stack [STK_D];
  logic [SP_W-1:0]   sp;

  logic [LEAF_W-1:0] n_eff;
  logic [LEAF_W-1:0] ql_c;
  logic [LEAF_W-1:0] qh_c;
  logic [LEAF_W-1:0] pos_c;
  logic [LEAF_W:0]   mid_sum;
  logic [LEAF_W-1:0] mid;
  logic [LEAF_W-1:0] mid_p1;
  logic [NODE_W:0]   child_l;
  logic [NODE_W:0]   child_r;
  logic [SP_W-1:0]   sp_m1;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // span saturates into 1..min(MAX_LEAVES, 2047)
  always_comb begin
    if (leaf_count == '0) begin
      n_eff = LEAF_W'(1);
    end else if (int'(leaf_count) > SPAN_MAX) begin
      n_eff = LEAF_W'(SPAN_MAX);
    end else begin
      n_eff = leaf_count;
    end
  end

  assign ql_c  = (range_low == '0) ? LEAF_W'(1) : range_low;
  assign qh_c  = (range_high > n_eff) ? n_eff : range_high;
  assign pos_c = (position == '0) ? LEAF_W'(1) :
                 ((position > n_eff) ? n_eff : position);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[LEAF_W:1];
  assign mid_p1  = mid + LEAF_W'(1);
  assign child_l = {node[NODE_W-1:0], 1'b0};
  assign child_r = {node[NODE_W-1:0], 1'b1};
  assign sp_m1   = sp - SP_W'(1);

  assign st.oob         = (node >= (NODE_W+1)'(TAG_DEPTH));
  assign st.covered     = (ql <= lo) && (hi <= qh);
  assign st.leaf        = (lo >= hi);
  assign st.want_left   = (ql <= mid);
  assign st.want_right  = (mid < qh);
  assign st.query_right = (pos > mid);
  assign st.range_empty = (ql > qh);
  assign st.stack_empty = (sp == '0);
  assign st.clear_last  = (clr_cnt == NODE_W'(TAG_DEPTH - 1));
  assign st.out_free    = !out_valid || out_ready;

  assign wr_en   = cmd.clear_step || cmd.add_write;
  assign wr_addr = cmd.clear_step ? clr_cnt : node[NODE_W-1:0];
  assign wr_data = cmd.clear_step ? '0 : (rd_data + val);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.visit_read || cmd.q_read) begin
      rd_data <= mem[node[NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= LEAF_COUNT_RESET;
    end else if (cfg_valid) begin
      leaf_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      sp      <= '0;
    end else if (cmd.load) begin
      clr_cnt <= '0;
      sp      <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
      if (cmd.push_right) begin
        sp <= sp + SP_W'(1);
      end else if (cmd.pop) begin
        sp <= sp_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_right) begin
      stack[sp[SI_W-1:0]] <= '{node: child_r, lo: mid_p1, hi: hi};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node <= (NODE_W+1)'(1);
      lo   <= LEAF_W'(1);
      hi   <= n_eff;
      ql   <= ql_c;
      qh   <= qh_c;
      pos  <= pos_c;
      val  <= add_value;
      sum  <= '0;
    end else begin
      if (cmd.go_left) begin
        node <= child_l;
        hi   <= mid;
      end else if (cmd.go_right) begin
        node <= child_r;
        lo   <= mid_p1;
      end else if (cmd.pop) begin
        node <= stack[sp_m1[SI_W-1:0]].node;
        lo   <= stack[sp_m1[SI_W-1:0]].lo;
        hi   <= stack[sp_m1[SI_W-1:0]].hi;
      end
      if (cmd.q_acc) begin
        sum <= sum + rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_sum <= sum;
    end
  end

endmodule

// ===== sv/range_add_point_query_segment_tree.sv =====
// Top level of the range-add / point-query segment tree.
// A segment tree over leaf positions 1..leaf_count keeps one 32-bit tag per node in a
// single-port-read, single-port-write memory of 4*MAX_LEAVES entries. One request is
// handled at a time; the memory port sets the pace. A range add walks the tree with a
// return stack, reading and then writing back the tag of each covered node. A point
// query reads and then accumulates the tag at each tree level, then loads the result
// register once it is free. A clear zeroes the memory one entry per cycle; the same
// sweep runs after reset and no request is taken until it ends, while configuration
// writes are always taken. A result waits in an output register, so the next request
// may start before it is taken. Write leaf_count while idle.
`include "assert_macros.svh"

module range_add_point_query_segment_tree #(
  parameter int MAX_LEAVES = 1024
) (
  input logic        clk,
  input logic        rst,
  rapq_req_if.sink   req,
  rapq_res_if.source res,
  rapq_cfg_if.sink   cfg
);
  import rapq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  rapq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .op       (req.op),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rapq_dp #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_data   (cfg.data),
    .range_low  (req.range_low),
    .range_high (req.range_high),
    .add_value  (req.add_value),
    .position   (req.position),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .point_sum  (res.point_sum),
    .cmd        (cmd),
    .st         (st)
  );

  `ASSERT_IMPLIES(a_no_accept_in_sweep, clk, rst, cmd.clear_step, !in_ready, "request taken during clear sweep")
  `ASSERT_IMPLIES(a_result_not_dropped, clk, rst, cmd.out_load, (!res.valid || res.ready), "result overwrites a pending one")
  `ASSERT_NEXT(a_read_then_write, clk, rst, cmd.visit_read, cmd.add_write, "tag read not followed by write back")

endmodule

// ===== dv/range_add_point_query_segment_tree_tb.sv =====
// Testbench for the range-add / point-query segment tree: directed and random requests.
module range_add_point_query_segment_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rapq_pkg::*;

  localparam int MAX_LEAVES = 1024;
  localparam int TAG_DEPTH = 4 * MAX_LEAVES;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_CYCLES = TAG_DEPTH + 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  // Shadow copy of the tag tree; expected point sums wait in pending_sums.
  class tag_tree_tracker;
    bit [DATA_W-1:0] tags [TAG_DEPTH];
    bit [LEAF_W-1:0] leaf_count = LEAF_COUNT_RESET;
    bit [DATA_W-1:0] pending_sums [$];
    int errors = 0;

    function void set_leaf_count(logic [LEAF_W-1:0] value);
      leaf_count = value;
    endfunction

    function int unsigned span();
      int unsigned n;
      n = leaf_count;
      if (n < 1) n = 1;
      if (n > MAX_LEAVES) n = MAX_LEAVES;
      return n;
    endfunction

    function void add_over(int unsigned node, int unsigned lo, int unsigned hi,
                           int unsigned ql, int unsigned qh, bit [DATA_W-1:0] amount);
      int unsigned mid;
      if (node >= TAG_DEPTH) return;
      if (ql <= lo && hi <= qh) begin
        tags[node] += amount;
        return;
      end
      if (lo >= hi) return;
      mid = (lo + hi) / 2;
      if (ql <= mid) add_over(2 * node, lo, mid, ql, qh, amount);
      if (mid < qh) add_over(2 * node + 1, mid + 1, hi, ql, qh, amount);
    endfunction

    function bit [DATA_W-1:0] path_sum(int unsigned pos, int unsigned n);
      int unsigned node, lo, hi, mid;
      bit [DATA_W-1:0] sum;
      node = 1;
      lo = 1;
      hi = n;
      sum = '0;
      while (node < TAG_DEPTH) begin
        sum += tags[node];
        if (lo >= hi) break;
        mid = (lo + hi) / 2;
        if (pos <= mid) begin
          node = 2 * node;
          hi = mid;
        end else begin
          node = 2 * node + 1;
          lo = mid + 1;
        end
      end
      return sum;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [LEAF_W-1:0] low_f,
                               logic [LEAF_W-1:0] high_f, logic [DATA_W-1:0] amount,
                               logic [LEAF_W-1:0] pos_f);
      int unsigned n, ql, qh, pos;
      n = span();
      case (op)
        OP_CLEAR: begin
          foreach (tags[i]) tags[i] = '0;
        end
        OP_ADD: begin
          ql = low_f;
          qh = high_f;
          if (ql < 1) ql = 1;
          if (qh > n) qh = n;
          if (ql <= qh) add_over(1, 1, n, ql, qh, amount);
        end
        OP_QUERY: begin
          pos = pos_f;
          if (pos < 1) pos = 1;
          if (pos > n) pos = n;
          pending_sums = {pending_sums, path_sum(pos, n)};
        end
        default: ;
      endcase
    endfunction

    function void check_sum(logic [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected point_sum, expected none, got %0d", $time, $signed(got));
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        $display("%0t: point_sum mismatch, expected %0d, got %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rapq_req_if req_ch ();
  rapq_res_if res_ch ();
  rapq_cfg_if cfg_ch ();

  range_add_point_query_segment_tree #(
    .MAX_LEAVES(MAX_LEAVES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  tag_tree_tracker tracker = new;
  bit idle_on = 1'b1;
  bit hold_off_pending = 1'b0;

  always #5 clk = ~clk;

  // Drive one request and hold it until the block takes it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [LEAF_W-1:0] low_f,
                              input logic [LEAF_W-1:0] high_f,
                              input logic [DATA_W-1:0] amount,
                              input logic [LEAF_W-1:0] pos_f);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.range_low <= low_f;
    req_ch.range_high <= high_f;
    req_ch.add_value <= amount;
    req_ch.position <= pos_f;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, low_f, high_f, amount, pos_f);
  endtask

  task automatic add_range(input logic [LEAF_W-1:0] low_f, input logic [LEAF_W-1:0] high_f,
                           input logic [DATA_W-1:0] amount);
    send_request(OP_ADD, low_f, high_f, amount, LEAF_W'($urandom));
  endtask

  task automatic query_at(input logic [LEAF_W-1:0] pos_f);
    send_request(OP_QUERY, LEAF_W'($urandom), LEAF_W'($urandom), $urandom, pos_f);
  endtask

  task automatic send_random(output bit counted);
    int unsigned pick, n;
    logic [OP_W-1:0] op;
    logic [LEAF_W-1:0] low_f, high_f, pos_f;
    n = tracker.span();
    pick = $urandom_range(0, 199);
    if (pick < 2) op = OP_CLEAR;
    else if (pick < 6) op = OP_UNUSED;
    else if (pick < 100) op = OP_ADD;
    else op = OP_QUERY;
    // Mostly ranges inside the span, some anywhere in the field
    if ($urandom_range(0, 6) == 0) begin
      low_f = LEAF_W'($urandom);
      high_f = LEAF_W'($urandom);
    end else begin
      low_f = LEAF_W'($urandom_range(1, n));
      high_f = LEAF_W'($urandom_range(low_f, n));
    end
    if ($urandom_range(0, 9) == 0) pos_f = LEAF_W'($urandom);
    else pos_f = LEAF_W'($urandom_range(1, n));
    send_request(op, low_f, high_f, $urandom, pos_f);
    counted = (op != OP_UNUSED);
  endtask

  task automatic write_leaf_count(input logic [LEAF_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_leaf_count(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending sum, then let a clear sweep finish.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int unsigned gap;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_pending = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) tracker.check_sum(res_ch.point_sum);
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [LEAF_W-1:0] settings [NUM_PHASES];
    int counted_items;
    bit counted;
    settings = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd2, 11'd1000, 11'd1024};
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_CLEAR;
    req_ch.range_low = '0;
    req_ch.range_high = '0;
    req_ch.add_value = '0;
    req_ch.position = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) drain();
      write_leaf_count(settings[p]);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      if (p == 3) hold_off_pending = 1'b1;
      if (p % 2 == 1) send_request(OP_CLEAR, '0, '0, '0, '0);

      if (p == 0) begin
        query_at(11'd1);
        add_range(11'd1, 11'd1024, 32'd5);
        add_range(11'd1, 11'd1, 32'h7FFF_FFFF);
        add_range(11'd1024, 11'd1024, 32'h8000_0000);
        add_range(11'd0, 11'd2047, 32'h1234_5678);
        add_range(11'd500, 11'd400, $urandom);
        add_range(11'd1025, 11'd2000, $urandom);
        add_range(11'd3, 11'd513, $urandom);
        query_at(11'd0);
        query_at(11'd1);
        query_at(11'd1024);
        query_at(11'd2047);
        query_at(11'd512);
        query_at(11'd513);
        send_request(OP_UNUSED, 11'd1, 11'd1024, 32'hFFFF_FFFF, 11'd1);
        add_range(11'd10, 11'd10, 32'h7FFF_FFFF);
        add_range(11'd10, 11'd10, 32'h7FFF_FFFF);
        query_at(11'd10);
        send_request(OP_CLEAR, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 11'h7FF);
        query_at(11'd700);
        add_range(11'd1, 11'd1024, 32'hFFFF_FFFF);
        query_at(11'd2);
        query_at(11'd1535);
      end

      counted_items = 0;
      while (counted_items < ITEMS_PER_PHASE) begin
        send_random(counted);
        if (counted) counted_items++;
      end
    end

    drain();
    if (tracker.errors == 0 && tracker.pending_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
